// ===== sv/sidar_pkg.sv =====
// ----------------------------------------------------------------------------
// sidar_pkg
// Shared types and codes for the connection arming table: event and result
// words, flag layout, controller command and status.
// ----------------------------------------------------------------------------
package sidar_pkg;

    localparam int CONN_W          = 10;
    localparam int CONN_SPAN       = 2 ** CONN_W;
    localparam int CONNECTIONS_DEF = 1024;
    // wide enough for the largest allowed connection count
    localparam int LIMIT_W         = 17;
    localparam int OPCODE_W        = 4;
    localparam int ACTION_W        = 3;
    localparam int CFG_IDX_W       = 1;
    localparam int FLAGS_W         = 9;

    typedef enum logic [OPCODE_W-1:0] {
        OP_OPEN       = 4'd0,
        OP_ERROR      = 4'd1,
        OP_REGISTER   = 4'd2,
        OP_UNREGISTER = 4'd3,
        OP_RD_READY   = 4'd4,
        OP_WR_READY   = 4'd5,
        OP_SPAWN_RD   = 4'd6,
        OP_SPAWN_WR   = 4'd7,
        OP_YIELD_RD   = 4'd8,
        OP_YIELD_WR   = 4'd9,
        OP_ATTACH_RD  = 4'd10,
        OP_DETACH_RD  = 4'd11,
        OP_ATTACH_WR  = 4'd12,
        OP_DETACH_WR  = 4'd13,
        OP_CLEAR_RD   = 4'd14,
        OP_CLEAR_WR   = 4'd15
    } opcode_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE     = 3'd0,
        ACT_WAKE_RD  = 3'd1,
        ACT_WAKE_WR  = 3'd2,
        ACT_START_RD = 3'd3,
        ACT_START_WR = 3'd4,
        ACT_MISUSE   = 3'd5
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INBOUND_AUTOSTART  = 1'd0,
        CFG_OUTBOUND_AUTOSTART = 1'd1
    } cfg_reg_t;

    // closed sits in the low bit
    typedef struct packed {
        logic wr_wait;
        logic rd_wait;
        logic wr_pend;
        logic rd_pend;
        logic wr_spawn;
        logic rd_spawn;
        logic wr_ready;
        logic rd_ready;
        logic closed;
    } flags_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [CONN_W-1:0]   conn_index;
    } sidar_req_t;

    typedef struct packed {
        logic [CONN_W-1:0]   out_index;
        logic [ACTION_W-1:0] action;
        logic                is_closed;
        logic                rd_ready;
        logic                wr_ready;
    } sidar_rsp_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic commit;
    } sidar_cmd_t;

    typedef struct packed {
        logic clear_last;
    } sidar_sts_t;

endpackage

// ===== sv/sidar_ram.sv =====
// ----------------------------------------------------------------------------
// sidar_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sidar_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/sidar_ctrl.sv =====
// ----------------------------------------------------------------------------
// sidar_ctrl
// Sequencer: clearing pass after reset, then fetch and update of one entry
// per event, with a result holding register toward the consumer.
// ----------------------------------------------------------------------------
module sidar_ctrl
    import sidar_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output sidar_cmd_t cmd,
    input  sidar_sts_t sts
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                // hold the fetched entry until the result register can take it
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== sv/sidar_dp.sv =====
// ----------------------------------------------------------------------------
// sidar_dp
// Datapath: flag table, event capture, flag update logic, autostart
// registers and the result register.
// ----------------------------------------------------------------------------
module sidar_dp
    import sidar_pkg::*;
#(
    parameter int CONNECTIONS = CONNECTIONS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sidar_req_t           req,
    output sidar_rsp_t           rsp,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    input  sidar_cmd_t           cmd,
    output sidar_sts_t           sts
);

    // only entries that a 10-bit index can reach are stored
    localparam int ENTRIES = (CONNECTIONS < CONN_SPAN) ? CONNECTIONS : CONN_SPAN;
    localparam int AW      = $clog2(ENTRIES);
    localparam logic [LIMIT_W-1:0] CONN_LIMIT = LIMIT_W'(CONNECTIONS);
    localparam logic [AW-1:0]      LAST_ADDR  = AW'(ENTRIES - 1);

    typedef struct packed {
        logic rdy;
        logic spawn;
        logic pend;
        logic waiter;
    } dir_t;

    typedef struct packed {
        dir_t d;
        logic wake;
        logic start;
        logic misuse;
    } dir_res_t;

    function automatic dir_res_t ready_evt(dir_t d, logic autostart);
        dir_res_t r;
        r       = '0;
        r.d     = d;
        r.d.rdy = 1'b1;
        if (d.waiter)
        begin
            r.wake = 1'b1;
        end
        else if ((d.pend || autostart) && !d.spawn)
        begin
            // toggles both, so autostart can leave pending set
            r.d.spawn = 1'b1;
            r.d.pend  = !d.pend;
            r.start   = 1'b1;
        end
        return r;
    endfunction

    function automatic dir_res_t spawn_evt(dir_t d);
        dir_res_t r;
        r   = '0;
        r.d = d;
        if (d.rdy && !d.spawn)
        begin
            r.d.spawn = 1'b1;
            r.start   = 1'b1;
        end
        else
        begin
            r.d.pend = 1'b1;
        end
        return r;
    endfunction

    function automatic dir_res_t yield_evt(dir_t d, logic autostart);
        dir_res_t r;
        r   = '0;
        r.d = d;
        if (!d.spawn)
        begin
            r.misuse = 1'b1;
        end
        else if (d.rdy && (d.pend || autostart))
        begin
            r.d.pend = 1'b0;
            r.start  = 1'b1;
        end
        else
        begin
            r.d.spawn = 1'b0;
        end
        return r;
    endfunction

    logic [OPCODE_W-1:0] op_reg;
    logic [CONN_W-1:0]   idx_reg;
    logic                in_range_reg;
    logic                in_auto_reg;
    logic                out_auto_reg;
    logic [AW-1:0]       clr_addr_reg;
    sidar_rsp_t          rsp_reg;
    sidar_rsp_t          rsp_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [FLAGS_W-1:0]  ram_wdata;
    logic [FLAGS_W-1:0]  ram_rdata;

    flags_t   cur;
    flags_t   nxt;
    action_t  act;
    dir_t     rd_d;
    dir_t     wr_d;
    dir_res_t res;
    logic     use_rd;
    logic     use_wr;
    logic     req_in_range;

    assign req_in_range = (LIMIT_W'(req.conn_index) < CONN_LIMIT);

    sidar_ram #(
        .WIDTH (FLAGS_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.capture),
        .rd_addr (req.conn_index[AW-1:0]),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        cur    = flags_t'(ram_rdata);
        nxt    = cur;
        act    = ACT_NONE;
        rd_d   = '{rdy: cur.rd_ready, spawn: cur.rd_spawn, pend: cur.rd_pend,
                   waiter: cur.rd_wait};
        wr_d   = '{rdy: cur.wr_ready, spawn: cur.wr_spawn, pend: cur.wr_pend,
                   waiter: cur.wr_wait};
        res    = '0;
        use_rd = 1'b0;
        use_wr = 1'b0;
        unique case (op_reg)
            OP_OPEN:
            begin
                nxt = '0;
            end
            OP_ERROR:
            begin
                if (!cur.closed)
                begin
                    nxt         = '0;
                    nxt.closed  = 1'b1;
                    nxt.rd_wait = cur.rd_wait;
                    nxt.wr_wait = cur.wr_wait;
                end
            end
            OP_REGISTER:
            begin
                if (cur.closed)
                begin
                    act = ACT_MISUSE;
                end
            end
            OP_UNREGISTER:
            begin
                if (!cur.closed)
                begin
                    act = ACT_MISUSE;
                end
                else
                begin
                    nxt = '0;
                end
            end
            OP_RD_READY:
            begin
                res    = ready_evt(rd_d, in_auto_reg);
                use_rd = !cur.closed;
            end
            OP_WR_READY:
            begin
                res    = ready_evt(wr_d, out_auto_reg);
                use_wr = !cur.closed;
            end
            OP_SPAWN_RD:
            begin
                res    = spawn_evt(rd_d);
                use_rd = !cur.closed;
            end
            OP_SPAWN_WR:
            begin
                res    = spawn_evt(wr_d);
                use_wr = !cur.closed;
            end
            OP_YIELD_RD:
            begin
                res    = yield_evt(rd_d, in_auto_reg);
                use_rd = !cur.closed;
            end
            OP_YIELD_WR:
            begin
                res    = yield_evt(wr_d, out_auto_reg);
                use_wr = !cur.closed;
            end
            OP_ATTACH_RD:
            begin
                if (cur.rd_wait)
                begin
                    act = ACT_MISUSE;
                end
                else
                begin
                    nxt.rd_wait = 1'b1;
                end
            end
            OP_DETACH_RD:
            begin
                if (!cur.rd_wait)
                begin
                    act = ACT_MISUSE;
                end
                else
                begin
                    nxt.rd_wait = 1'b0;
                end
            end
            OP_ATTACH_WR:
            begin
                if (cur.wr_wait)
                begin
                    act = ACT_MISUSE;
                end
                else
                begin
                    nxt.wr_wait = 1'b1;
                end
            end
            OP_DETACH_WR:
            begin
                if (!cur.wr_wait)
                begin
                    act = ACT_MISUSE;
                end
                else
                begin
                    nxt.wr_wait = 1'b0;
                end
            end
            OP_CLEAR_RD:
            begin
                nxt.rd_ready = 1'b0;
            end
            OP_CLEAR_WR:
            begin
                nxt.wr_ready = 1'b0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase

        if (use_rd)
        begin
            nxt.rd_ready = res.d.rdy;
            nxt.rd_spawn = res.d.spawn;
            nxt.rd_pend  = res.d.pend;
            nxt.rd_wait  = res.d.waiter;
            if (res.misuse)
            begin
                act = ACT_MISUSE;
            end
            else if (res.wake)
            begin
                act = ACT_WAKE_RD;
            end
            else if (res.start)
            begin
                act = ACT_START_RD;
            end
        end
        if (use_wr)
        begin
            nxt.wr_ready = res.d.rdy;
            nxt.wr_spawn = res.d.spawn;
            nxt.wr_pend  = res.d.pend;
            nxt.wr_wait  = res.d.waiter;
            if (res.misuse)
            begin
                act = ACT_MISUSE;
            end
            else if (res.wake)
            begin
                act = ACT_WAKE_WR;
            end
            else if (res.start)
            begin
                act = ACT_START_WR;
            end
        end

        // out of range: misuse, flags read as zero
        if (!in_range_reg)
        begin
            nxt = '0;
            act = ACT_MISUSE;
        end

        rsp_next.out_index = idx_reg;
        rsp_next.action    = act;
        rsp_next.is_closed = nxt.closed;
        rsp_next.rd_ready  = nxt.rd_ready;
        rsp_next.wr_ready  = nxt.wr_ready;
    end

    // table write: clearing pass or entry update
    always_comb
    begin
        if (cmd.clear_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = cmd.commit && in_range_reg;
            ram_waddr = idx_reg[AW-1:0];
            ram_wdata = FLAGS_W'(nxt);
        end
    end

    assign sts.clear_last = (clr_addr_reg == LAST_ADDR);
    assign rsp            = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            in_auto_reg  <= 1'b0;
            out_auto_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_INBOUND_AUTOSTART:  in_auto_reg  <= cfg_data;
                    CFG_OUTBOUND_AUTOSTART: out_auto_reg <= cfg_data;
                    default:                in_auto_reg  <= in_auto_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= req.opcode;
            idx_reg      <= req.conn_index;
            in_range_reg <= req_in_range;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ===== sv/socket_io_dispatch_arming_unit.sv =====
// ----------------------------------------------------------------------------
// socket_io_dispatch_arming_unit
// Per-connection arming table: each event updates one connection's flags
// and answers with one action (none, wake, start or misuse).
//
//   channel  handshake              payload
//   req      req_valid/req_ready    sidar_req_t  (opcode, conn_index)
//   rsp      rsp_valid/rsp_ready    sidar_rsp_t  (index, action, flags)
//   cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// For each word the accept cycle reads the flag table; ST_MODIFY then updates
// the entry and loads the result register (one RAM port pair), and only then
// is the next word accepted. After reset a clearing pass zeroes the table, one
// entry per cycle over min(CONNECTIONS, 1024) entries, while req_ready stays low.
// A stalled result holds the update of the following word; cfg is always ready.
// ----------------------------------------------------------------------------
module socket_io_dispatch_arming_unit
    import sidar_pkg::*;
#(
    parameter int CONNECTIONS = CONNECTIONS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  sidar_req_t           req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output sidar_rsp_t           rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    sidar_cmd_t cmd;
    sidar_sts_t sts;

    assign cfg_ready = 1'b1;

    sidar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    sidar_dp #(
        .CONNECTIONS (CONNECTIONS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
